### src/shabs_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
package shabs_pkg;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    BSEL_IN   = 2'd0,
    BSEL_MARK = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic        absorb;
    byte_sel_t   byte_sel;
    logic        len_add;
    logic        init_work;
    logic        round;
    logic        fold;
    logic        reinit;
    logic [5:0]  round_idx;
    logic [2:0]  word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] byte_cnt;
  } dp_status_t;

endpackage

### src/shabs_dp.sv
// Datapath: block buffer, message schedule, round logic, chain value, bit length.
module shabs_dp #(
  parameter int LenBits = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  shabs_pkg::dp_cmd_t   cmd,
  input  logic [7:0]           in_data_byte,
  output shabs_pkg::dp_status_t status,
  output logic [31:0]          digest_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0]        chain_r [8];
  logic [31:0]        work_r  [8];
  logic [31:0]        win_r   [16];
  logic [5:0]         cnt_r;
  logic [LenBits-1:0] len_r;

  logic [63:0] len64;
  logic [7:0]  len_byte;
  logic [7:0]  abs_byte;
  logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new;

  assign len64    = 64'(len_r);
  // length goes out most significant byte first, at block bytes 56..63
  assign len_byte = 8'(len64 >> {~cnt_r[2:0], 3'b000});

  always_comb begin
    unique case (cmd.byte_sel)
      shabs_pkg::BSEL_IN:   abs_byte = in_data_byte;
      shabs_pkg::BSEL_MARK: abs_byte = shabs_pkg::PAD_MARK;
      shabs_pkg::BSEL_ZERO: abs_byte = 8'h00;
      shabs_pkg::BSEL_LEN:  abs_byte = len_byte;
      default:              abs_byte = 8'h00;
    endcase
  end

  always_comb begin
    big1  = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    big0  = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    ch    = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    maj   = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t1    = work_r[7] + big1 + ch + shabs_pkg::ROUND_K[cmd.round_idx] + win_r[0];
    t2    = big0 + maj;
    s0    = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1    = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_new = win_r[0] + s0 + win_r[9] + s1;
  end

  // window holds W[t]..W[t+15]; bytes shift in at the low byte of win_r[15] while loading
  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[15] <= {win_r[15][23:0], abs_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_new;
    end
    if (cmd.init_work) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= shabs_pkg::INIT_HASH[i];
      end
      cnt_r <= 6'd0;
      len_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
      end
      if (cmd.absorb) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (cmd.len_add) begin
        len_r <= len_r + LenBits'(8);
      end
    end
  end

  assign status.byte_cnt = cnt_r;
  assign digest_word     = chain_r[cmd.word_idx];

endmodule

### src/shabs_ctrl.sv
// Controller: sequences byte loading, padding, compression rounds and digest output.
module shabs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_byte_present,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word,
  output shabs_pkg::dp_cmd_t    cmd,
  input  shabs_pkg::dp_status_t status
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic       close_r, close_nxt;
  logic       mark_r, mark_nxt;
  logic       lenph_r, lenph_nxt;
  logic       lendone_r, lendone_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       cnt_top;
  logic       in_req;
  logic       out_req;

  assign cnt_top = (status.byte_cnt == 6'd63);
  assign in_req  = in_valid && in_ready;
  assign out_req = out_valid && out_ready;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_word_index = widx_r;
  assign out_last_word  = (widx_r == 3'd7);

  always_comb begin
    state_nxt   = state_r;
    close_nxt   = close_r;
    mark_nxt    = mark_r;
    lenph_nxt   = lenph_r;
    lendone_nxt = lendone_r;
    rnd_nxt     = rnd_r;
    widx_nxt    = widx_r;
    cmd           = '0;
    cmd.byte_sel  = shabs_pkg::BSEL_IN;
    cmd.round_idx = rnd_r;
    cmd.word_idx  = widx_r;
    unique case (state_r)
      S_IDLE: begin
        mark_nxt    = 1'b0;
        lenph_nxt   = 1'b0;
        lendone_nxt = 1'b0;
        if (in_req) begin
          cmd.absorb  = in_byte_present;
          cmd.len_add = in_byte_present;
          close_nxt   = in_last_byte;
          if (in_byte_present && cnt_top) begin
            state_nxt = S_LOAD;
          end else if (in_last_byte) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.absorb = 1'b1;
        if (!mark_r) begin
          cmd.byte_sel = shabs_pkg::BSEL_MARK;
          mark_nxt     = 1'b1;
        end else if (lenph_r || status.byte_cnt == 6'd56) begin
          cmd.byte_sel = shabs_pkg::BSEL_LEN;
          lenph_nxt    = 1'b1;
          lendone_nxt  = cnt_top;
        end else begin
          cmd.byte_sel = shabs_pkg::BSEL_ZERO;
        end
        if (cnt_top) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.init_work = 1'b1;
        rnd_nxt       = 6'd0;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        priority if (close_r && lendone_r) begin
          widx_nxt  = 3'd0;
          state_nxt = S_OUT;
        end else if (close_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_req) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            cmd.reinit = 1'b1;
            close_nxt  = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      close_r   <= 1'b0;
      mark_r    <= 1'b0;
      lenph_r   <= 1'b0;
      lendone_r <= 1'b0;
      rnd_r     <= 6'd0;
      widx_r    <= 3'd0;
    end else begin
      state_r   <= state_nxt;
      close_r   <= close_nxt;
      mark_r    <= mark_nxt;
      lenph_r   <= lenph_nxt;
      lendone_r <= lendone_nxt;
      rnd_r     <= rnd_nxt;
      widx_r    <= widx_nxt;
    end
  end

endmodule

### src/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   in_data_byte, in_byte_present, in_last_byte
//   out_     output     out_valid/out_ready out_digest_word, out_word_index, out_last_word
//
// The 64th byte of a block starts a compression: one step loads the working
// variables, 64 rounds run on the single round unit, one step folds into the
// chain value. Closing pads one byte per cycle and compresses once or twice
// more, then the eight words leave one per accepted request. in_ready is low
// from a block-filling or closing request until the block is idle again.
// Reset is synchronous and loads the initial hash words.
module sha256_byte_stream_hasher #(
  parameter int LENGTH_COUNTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  shabs_pkg::dp_cmd_t    cmd;
  shabs_pkg::dp_status_t status;

  shabs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word),
    .cmd             (cmd),
    .status          (status)
  );

  shabs_dp #(
    .LenBits (LENGTH_COUNTER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .status       (status),
    .digest_word  (out_digest_word)
  );

endmodule

### verif/sha256_digest_checker.sv
// Watches both channels of the SHA-256 hasher, predicts digests and compares them.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output logic [31:0] digest_words_due,
  output logic [31:0] mismatch_count
);

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int PAD_STOP = 56;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [31:0] hash_word;
    logic [2:0]  word_pos;
    logic        is_last;
  } digest_entry_t;

  digest_entry_t pending_digest [$];

  logic [31:0] chain [8];
  logic [7:0]  block_bytes [64];
  int          fill;
  logic [63:0] bit_len;
  int          errors;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Adds one byte to the current block; a full block is compressed into the chain.
  function automatic void absorb_byte(input logic [7:0] b);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    block_bytes[fill] = b;
    fill++;
    if (fill == 64) begin
      fill = 0;
      for (int t = 0; t < 16; t++) begin
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
        chain[i] = chain[i] + v[i];
      end
    end
  endfunction

  always @(posedge clk) begin
    digest_entry_t want;
    digest_entry_t fresh;
    logic [63:0]   len_snap;
    if (!rst_n) begin
      chain = SHA_IV;
      fill = 0;
      bit_len = '0;
      errors = 0;
      pending_digest.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_byte_present) begin
          absorb_byte(in_data_byte);
          bit_len = bit_len + 64'd8;
        end
        if (in_last_byte) begin
          len_snap = bit_len;
          absorb_byte(PAD_BYTE);
          while (fill != PAD_STOP) absorb_byte(8'h00);
          for (int k = 7; k >= 0; k--) absorb_byte(len_snap[8*k +: 8]);
          for (int k = 0; k < 8; k++) begin
            fresh = '{hash_word: chain[k], word_pos: 3'(k), is_last: (k == 7)};
            pending_digest = {pending_digest, fresh};
          end
          chain = SHA_IV;
          bit_len = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_digest.size() == 0) begin
          $display("%0t unexpected digest word %h index %0d last %0b", $time,
                   out_digest_word, out_word_index, out_last_word);
          errors++;
        end else begin
          want = pending_digest.pop_front();
          if (out_digest_word !== want.hash_word) begin
            $display("%0t digest_word: expected %h, actual %h", $time,
                     want.hash_word, out_digest_word);
            errors++;
          end
          if (out_word_index !== want.word_pos) begin
            $display("%0t word_index: expected %0d, actual %0d", $time,
                     want.word_pos, out_word_index);
            errors++;
          end
          if (out_last_word !== want.is_last) begin
            $display("%0t last_word: expected %0b, actual %0b", $time,
                     want.is_last, out_last_word);
            errors++;
          end
        end
      end
    end
    digest_words_due <= 32'(pending_digest.size());
    mismatch_count <= 32'(errors);
  end

endmodule

### verif/sha256_byte_stream_hasher_tb.sv
// Stimulus, clock, reset and verdict for the SHA-256 byte stream hasher.
module sha256_byte_stream_hasher_tb;

  localparam int ITEM_TARGET = 270;
  localparam int DRAIN_CYCLES = 150;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic [31:0] digest_words_due;
  logic [31:0] mismatch_count;

  int   items_sent;
  bit   src_eager;
  bit   sink_eager;
  int   ready_hold;

  sha256_byte_stream_hasher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  sha256_digest_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_byte_present  (in_byte_present),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_word  (out_digest_word),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word),
    .digest_words_due (digest_words_due),
    .mismatch_count   (mismatch_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) sink_eager <= ~sink_eager;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (!sink_eager && $urandom_range(0, 3) == 0) begin
      ready_hold <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [7:0] d, input logic p, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_byte_present <= p;
    in_last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (p || l) items_sent++;
    gap = src_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_words_due != 0) @(posedge clk);
  endtask

  // Random bytes with stray empty requests; closes on the last byte or separately.
  task automatic send_message(input int len);
    bit close_on_byte;
    close_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int msg_no;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_byte_present = 1'b0;
    in_last_byte = 1'b0;
    out_ready = 1'b0;
    ready_hold = 0;
    sink_eager = 1'b0;
    src_eager = 1'b0;
    items_sent = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, closed by a request with no byte
    send_item(8'hff, 1'b0, 1'b1);
    wait_drained();
    // "abc", closed on its last byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // byte extremes, an ignored request, then a separate close
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // full block in a burst, last byte closing it
    src_eager = 1'b1;
    for (int i = 0; i < 64; i++) send_item(8'(i * 37), 1'b1, i == 63);
    src_eager = 1'b0;

    msg_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(55, 57);
        1: len = $urandom_range(63, 65);
        2: len = 0;
        3: len = $urandom_range(119, 120);
        default: len = $urandom_range(1, 20);
      endcase
      src_eager = ($urandom_range(0, 3) == 0);
      send_message(len);
      msg_no++;
      if (msg_no % 4 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
src/shabs_pkg.sv
src/shabs_dp.sv
src/shabs_ctrl.sv
src/sha256_byte_stream_hasher.sv
verif/sha256_digest_checker.sv
verif/sha256_byte_stream_hasher_tb.sv
